### src/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

    // Command codes carried in the cmd field; codes 6 and 7 are unused.
    localparam logic [2:0] CMD_REVERSE    = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_BACK   = 3'd4;
    localparam logic [2:0] CMD_READ       = 3'd5;

    // One command transfer.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] ch;
        logic [9:0] index;
    } cmd_item_t;

    // One result transfer.
    typedef struct packed {
        logic [7:0]  data;
        logic        ok;
        logic [10:0] size;
    } rsp_item_t;

    // Controller sequence.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_rsp;
    } ctrl_t;

endpackage

### src/cdq_ctrl.sv
`timescale 1ns / 1ps

module cdq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cdq_pkg::ctrl_t ctrl
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdq_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next       = state_reg;
        ctrl.capture     = 1'b0;
        ctrl.execute     = 1'b0;
        ctrl.load_rsp    = 1'b0;
        cmd_stall        = 1'b1;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = cdq_pkg::ST_ACCESS;
                end
            end
            cdq_pkg::ST_ACCESS:
            begin
                ctrl.execute = 1'b1;
                state_next   = cdq_pkg::ST_RESULT;
            end
            cdq_pkg::ST_RESULT:
            begin
                // Load the result once the output register is free or being emptied.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ctrl.load_rsp  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = cdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

### src/cdq_dpath.sv
`timescale 1ns / 1ps

module cdq_dpath
#(
    parameter int DEPTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cdq_pkg::ctrl_t     ctrl,
    input  cdq_pkg::cmd_item_t cmd_item,
    output cdq_pkg::rsp_item_t rsp_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int XW = (CW > 10) ? CW : 10;
    localparam int OW = (CW > 11) ? CW : 11;

    // Character store, one port, registered read.
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;

    // Deque state.
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rev_reg;
    logic          rev_next;

    // Captured command.
    logic [2:0]    cmd_reg;
    logic [7:0]    ch_reg;
    logic [9:0]    idx_reg;

    // Outcome of the access step.
    logic          ok_reg;
    logic          ok_next;
    logic          rsel_reg;
    logic          rsel_next;
    cdq_pkg::rsp_item_t rsp_item_reg;

    // Access-step signals.
    logic          full;
    logic          empty;
    logic          idx_ok;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] count_x;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [CW-1:0] off;
    logic [SW-1:0] sum;
    logic [AW-1:0] slot_addr;
    logic [AW-1:0] addr;
    logic          wr_en;
    logic          rd_en;
    logic [OW-1:0] count_o;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign idx_x   = XW'(idx_reg);
    assign count_x = XW'(count_reg);
    assign idx_ok  = (idx_x < count_x);

    // Circular neighbors of the head slot.
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Physical slot of an offset from head, wrapped once.
    assign sum       = SW'(head_reg) + SW'(off);
    assign slot_addr = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);

    // Decode the command against the current state.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        ok_next    = 1'b0;
        rsel_next  = 1'b0;
        off        = '0;
        addr       = slot_addr;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        case (cmd_reg)
            cdq_pkg::CMD_REVERSE:
            begin
                rev_next = !rev_reg;
                ok_next  = 1'b1;
            end
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK:
            begin
                if (!full)
                begin
                    ok_next    = 1'b1;
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if ((cmd_reg == cdq_pkg::CMD_PUSH_FRONT) != rev_reg)
                    begin
                        addr      = head_dec;
                        head_next = head_dec;
                    end
                    else
                    begin
                        off = count_reg;
                    end
                end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK:
            begin
                if (!empty)
                begin
                    ok_next    = 1'b1;
                    rsel_next  = 1'b1;
                    rd_en      = 1'b1;
                    count_next = count_reg - CW'(1);
                    if ((cmd_reg == cdq_pkg::CMD_POP_FRONT) != rev_reg)
                    begin
                        addr      = head_reg;
                        head_next = head_inc;
                    end
                    else
                    begin
                        off = count_reg - CW'(1);
                    end
                end
            end
            cdq_pkg::CMD_READ:
            begin
                if (idx_ok)
                begin
                    ok_next   = 1'b1;
                    rsel_next = 1'b1;
                    rd_en     = 1'b1;
                    off       = rev_reg ? (count_reg - CW'(1) - CW'(idx_x))
                                        : CW'(idx_x);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Deque state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else if (ctrl.execute)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    // Command capture and access outcome.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= cmd_item.cmd;
            ch_reg  <= cmd_item.ch;
            idx_reg <= cmd_item.index;
        end
        if (ctrl.execute)
        begin
            ok_reg   <= ok_next;
            rsel_reg <= rsel_next;
        end
    end

    // Store access.
    always_ff @(posedge clk)
    begin
        if (ctrl.execute && wr_en)
        begin
            mem[addr] <= ch_reg;
        end
        if (ctrl.execute && rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign count_o = OW'(count_reg);

    // Output register.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_rsp)
        begin
            rsp_item_reg.data <= rsel_reg ? rd_data_reg : 8'd0;
            rsp_item_reg.ok   <= ok_reg;
            rsp_item_reg.size <= count_o[10:0];
        end
    end

    assign rsp_item = rsp_item_reg;

endmodule

### src/char_deque_with_reverse_top.sv
// A command taken by the block passes through the capture, single-port store access
// and result-load steps of the controller sequence; result load waits until the
// output register is free or being emptied, and rsp_valid is registered from it. No
// new command is taken until the previous one has been loaded into the output register.
// A finished result waits in the output register while the next command is taken.
// Reset (rst_n low, asynchronous) empties the deque, clears the reverse flag and the
// result valid; the character store itself is not cleared.
`timescale 1ns / 1ps

module char_deque_with_reverse_top
#(
    parameter int DEPTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cdq_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cdq_pkg::rsp_item_t rsp_item
);

    cdq_pkg::ctrl_t ctrl;

    cdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl      (ctrl)
    );

    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmd_item (cmd_item),
        .rsp_item (rsp_item)
    );

    // A command transfer keeps the block busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while the previous one was still in progress");

    // A refused result carries a zero byte, as does an empty-handed one; only the refused case is asserted.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.ok |-> rsp_item.data == 8'd0)
        else $error("refused result carries a nonzero byte");

    // A new result only comes out of a command in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_stall))
        else $error("result appeared without a command in progress");

endmodule

### tb/tb_char_deque_with_reverse_top.sv
`timescale 1ns / 1ps

module tb_char_deque_with_reverse_top;

    localparam int DEPTH       = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 12;

    // Codes the block must ignore.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    cdq_pkg::cmd_item_t cmd_item;
    logic               rsp_valid;
    logic               rsp_stall;
    cdq_pkg::rsp_item_t rsp_item;

    // Shadow copy of the deque contents and pointers.
    logic [7:0]  shadow_mem [0:DEPTH-1];
    logic [9:0]  shadow_head;
    logic [10:0] shadow_count;
    logic        shadow_flipped;

    // Responses owed by the block, oldest first.
    cdq_pkg::rsp_item_t owed_rsp [$];

    int error_count;
    int cycle_count;
    int burst_left;
    bit hold_req;
    int hold_left;
    int stall_mode;
    int stall_mode_left;
    int stall_phase;

    char_deque_with_reverse_top #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Applies one accepted command to the shadow deque and records the response it owes.
    function automatic void deque_apply(input cdq_pkg::cmd_item_t it);
        cdq_pkg::rsp_item_t r;
        logic [9:0]         slot;
        logic [10:0]        offset;
        r = '0;
        case (it.cmd)
            cdq_pkg::CMD_REVERSE:
            begin
                shadow_flipped = !shadow_flipped;
                r.ok = 1'b1;
            end
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK:
            begin
                if (shadow_count < DEPTH)
                begin
                    if ((it.cmd == cdq_pkg::CMD_PUSH_FRONT) != shadow_flipped)
                    begin
                        shadow_head = shadow_head - 10'd1;
                        shadow_mem[shadow_head] = it.ch;
                    end
                    else
                    begin
                        slot = shadow_head + shadow_count[9:0];
                        shadow_mem[slot] = it.ch;
                    end
                    shadow_count = shadow_count + 11'd1;
                    r.ok = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK:
            begin
                if (shadow_count != 0)
                begin
                    if ((it.cmd == cdq_pkg::CMD_POP_FRONT) != shadow_flipped)
                    begin
                        r.data = shadow_mem[shadow_head];
                        shadow_head = shadow_head + 10'd1;
                    end
                    else
                    begin
                        slot = shadow_head + shadow_count[9:0] - 10'd1;
                        r.data = shadow_mem[slot];
                    end
                    shadow_count = shadow_count - 11'd1;
                    r.ok = 1'b1;
                end
            end
            cdq_pkg::CMD_READ:
            begin
                if ({1'b0, it.index} < shadow_count)
                begin
                    offset = shadow_flipped ? shadow_count - 11'd1 - {1'b0, it.index}
                                            : {1'b0, it.index};
                    slot = shadow_head + offset[9:0];
                    r.data = shadow_mem[slot];
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.size = shadow_count;
        owed_rsp.insert(owed_rsp.size(), r);
    endfunction

    function automatic cdq_pkg::cmd_item_t make_cmd(input logic [2:0] cmd,
                                                    input logic [7:0] ch,
                                                    input logic [9:0] idx);
        cdq_pkg::cmd_item_t it;
        it.cmd   = cmd;
        it.ch    = ch;
        it.index = idx;
        return it;
    endfunction

    // Offers one command, in bursts with random gaps, and waits for its transfer.
    task automatic send_cmd(input cdq_pkg::cmd_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                cmd_item  <= cdq_pkg::cmd_item_t'(21'($urandom));
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        burst_left--;
        deque_apply(it);
    endtask

    // Sends one random command with the given percentages; the rest are spare codes.
    task automatic send_mix(input int push_w, input int pop_w, input int rev_w,
                            input int read_w);
        int                 roll;
        cdq_pkg::cmd_item_t it;
        roll     = $urandom_range(0, 99);
        it.ch    = 8'($urandom_range(0, 255));
        it.index = 10'($urandom_range(0, DEPTH - 1));
        if (roll < push_w)
            it.cmd = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_BACK;
        else if (roll < push_w + pop_w)
            it.cmd = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_BACK;
        else if (roll < push_w + pop_w + rev_w)
            it.cmd = cdq_pkg::CMD_REVERSE;
        else if (roll < push_w + pop_w + rev_w + read_w)
        begin
            it.cmd = cdq_pkg::CMD_READ;
            // Mostly hit the held range; otherwise keep the full index span.
            if ($urandom_range(0, 3) != 0 && shadow_count != 0)
                it.index = 10'($urandom_range(0, shadow_count - 1));
        end
        else
            it.cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        send_cmd(it);
    endtask

    // Empty deque refusals, spare codes, pushes and pops at both ends, reads in both orders.
    task automatic test_directed();
        send_cmd(make_cmd(cdq_pkg::CMD_POP_FRONT,  8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_POP_BACK,   8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd0));
        send_cmd(make_cmd(CMD_SPARE_6,             8'hFF, 10'd1023));
        send_cmd(make_cmd(CMD_SPARE_7,             8'hFF, 10'd1023));
        send_cmd(make_cmd(cdq_pkg::CMD_REVERSE,    8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_FRONT, 8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_BACK,  8'hFF, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_FRONT, 8'hA5, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd1));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd2));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd3));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd1023));
        send_cmd(make_cmd(cdq_pkg::CMD_REVERSE,    8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd2));
        send_cmd(make_cmd(cdq_pkg::CMD_POP_FRONT,  8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_POP_BACK,   8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_REVERSE,    8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_BACK,  8'h5A, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_POP_FRONT,  8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_POP_BACK,   8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_POP_BACK,   8'h00, 10'd0));
    endtask

    // Random commands around a small fill level, with one long output hold-off.
    task automatic test_mixed();
        for (int n = 0; n < 50; n++)
        begin
            if (n == 20)
                hold_req = 1'b1;
            send_mix(35, 30, 10, 20);
        end
    endtask

    // Push until the store is full, with reads and reversals along the way.
    task automatic test_fill();
        while (shadow_count < DEPTH)
            send_mix(97, 0, 1, 2);
    endtask

    // Refused pushes and reads at both end positions while full, in both orders, then a pop and a refill.
    task automatic test_full();
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_FRONT, 8'hFF, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_BACK,  8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd1023));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_REVERSE,    8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd1023));
        send_cmd(make_cmd(cdq_pkg::CMD_READ,       8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_BACK,  8'h11, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_POP_BACK,   8'h00, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_FRONT, 8'h22, 10'd0));
        send_cmd(make_cmd(cdq_pkg::CMD_PUSH_BACK,  8'h33, 10'd0));
    endtask

    // Pop-heavy traffic from the full state.
    task automatic test_drain();
        repeat (40)
            send_mix(10, 70, 5, 12);
    endtask

    // Receiver stall pattern, with a counted hold-off on request.
    initial
    begin
        rsp_stall       = 1'b0;
        hold_left       = 0;
        stall_mode      = 0;
        stall_mode_left = 0;
        stall_phase     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (stall_mode_left == 0)
                begin
                    stall_mode      = $urandom_range(0, 3);
                    stall_mode_left = $urandom_range(20, 80);
                end
                stall_mode_left--;
                stall_phase = (stall_phase + 1) % 3;
                case (stall_mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= 1'($urandom_range(0, 1));
                    2: rsp_stall <= (stall_phase == 0);
                    default: rsp_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // Response check against the oldest owed response.
    always @(posedge clk)
    begin
        cdq_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_rsp.size() == 0)
            begin
                $error("unexpected response transfer: data %0d ok %0d size %0d",
                       rsp_item.data, rsp_item.ok, rsp_item.size);
                error_count++;
            end
            else
            begin
                want = owed_rsp.pop_front();
                if (rsp_item.data !== want.data)
                begin
                    $error("data mismatch: expected %0d, actual %0d", want.data, rsp_item.data);
                    error_count++;
                end
                if (rsp_item.ok !== want.ok)
                begin
                    $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp_item.ok);
                    error_count++;
                end
                if (rsp_item.size !== want.size)
                begin
                    $error("size mismatch: expected %0d, actual %0d", want.size, rsp_item.size);
                    error_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        error_count    = 0;
        cycle_count    = 0;
        burst_left     = 0;
        hold_req       = 1'b0;
        shadow_head    = '0;
        shadow_count   = '0;
        shadow_flipped = 1'b0;
        cmd_valid      = 1'b0;
        cmd_item       = '0;
        rst_n          = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_mixed();
        test_fill();
        test_full();
        test_drain();

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
